### src/sapd_pkg.sv
package sapd_pkg;

  // capacity of one aggregation packet
  localparam int MAX_UNITS = 16;
  localparam int UCNT_W    = $clog2(MAX_UNITS + 1);

  localparam logic [4:0] TYPE_SPS = 5'd7;
  localparam logic [4:0] TYPE_PPS = 5'd8;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_BODY,
    PH_DISCARD
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER,
    KIND_LENGTH,
    KIND_PAYLOAD,
    KIND_DISCARD
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_FORBIDDEN,
    ERR_TRUNC_LENGTH,
    ERR_TRUNC_BODY,
    ERR_TOO_MANY
  } err_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_last;
  } beat_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  out_byte;
    logic [3:0]  unit_index;
    logic [15:0] unit_length;
    logic        unit_first;
    logic        unit_final;
    logic [4:0]  unit_type;
    logic [1:0]  ref_idc;
    logic        first_sps;
    logic        first_pps;
    logic        packet_end;
    err_t        error_code;
  } result_t;

endpackage

### src/sapd_if.sv
// payload byte channel
interface sapd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       packet_last;

  modport source (output valid, data_byte, packet_last, input ready);
  modport sink (input valid, data_byte, packet_last, output ready);
endinterface

// classified byte channel
interface sapd_result_if;
  logic                valid;
  logic                ready;
  sapd_pkg::kind_t     kind;
  logic [7:0]          out_byte;
  logic [3:0]          unit_index;
  logic [15:0]         unit_length;
  logic                unit_first;
  logic                unit_final;
  logic [4:0]          unit_type;
  logic [1:0]          ref_idc;
  logic                first_sps;
  logic                first_pps;
  logic                packet_end;
  sapd_pkg::err_t      error_code;

  modport source (output valid, kind, out_byte, unit_index, unit_length, unit_first,
                  unit_final, unit_type, ref_idc, first_sps, first_pps, packet_end,
                  error_code, input ready);
  modport sink (input valid, kind, out_byte, unit_index, unit_length, unit_first,
                unit_final, unit_type, ref_idc, first_sps, first_pps, packet_end,
                error_code, output ready);
endinterface

### src/sapd_in_stage.sv
module sapd_in_stage (
  input  logic            clk,
  input  logic            rst,
  sapd_byte_if.sink       payload,
  input  logic            take,
  output logic            beat_valid,
  output sapd_pkg::beat_t beat
);

  // register is free when empty or being drained this cycle
  assign payload.ready = !beat_valid || take;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else if (payload.ready) begin
      beat_valid <= payload.valid;
    end
  end

  // beat capture
  always_ff @(posedge clk) begin
    if (payload.valid && payload.ready) begin
      beat.data_byte   <= payload.data_byte;
      beat.packet_last <= payload.packet_last;
    end
  end

endmodule

### src/sapd_parser.sv
module sapd_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  sapd_pkg::beat_t   beat,
  output sapd_pkg::result_t res
);

  sapd_pkg::phase_t             phase, phase_next;
  logic [7:0]                   length_high, length_high_next;
  logic [15:0]                  bytes_left, bytes_left_next;
  logic [15:0]                  current_length, current_length_next;
  logic [sapd_pkg::UCNT_W-1:0]  unit_count, unit_count_next;
  logic [4:0]                   current_type, current_type_next;
  logic [1:0]                   stored_nri, stored_nri_next;
  logic                         seen_sps, seen_sps_next;
  logic                         seen_pps, seen_pps_next;
  logic                         cur_sps, cur_sps_next;
  logic                         cur_pps, cur_pps_next;
  logic [sapd_pkg::UCNT_W+3:0]  count_wide;
  logic [15:0]                  new_length;
  logic [4:0]                   body_type;
  logic                         body_first;
  logic                         body_sps;
  logic                         body_pps;

  assign count_wide = {4'b0, unit_count};
  assign new_length = {length_high, beat.data_byte};
  assign body_first = (bytes_left == current_length);
  assign body_type  = body_first ? beat.data_byte[4:0] : current_type;
  assign body_sps   = body_first ? ((body_type == sapd_pkg::TYPE_SPS) && !seen_sps) : cur_sps;
  assign body_pps   = body_first ? ((body_type == sapd_pkg::TYPE_PPS) && !seen_pps) : cur_pps;

  // packet state register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= sapd_pkg::PH_HEADER;
      length_high    <= '0;
      bytes_left     <= '0;
      current_length <= '0;
      unit_count     <= '0;
      current_type   <= '0;
      stored_nri     <= '0;
      seen_sps       <= 1'b0;
      seen_pps       <= 1'b0;
      cur_sps        <= 1'b0;
      cur_pps        <= 1'b0;
    end else if (take) begin
      phase          <= phase_next;
      length_high    <= length_high_next;
      bytes_left     <= bytes_left_next;
      current_length <= current_length_next;
      unit_count     <= unit_count_next;
      current_type   <= current_type_next;
      stored_nri     <= stored_nri_next;
      seen_sps       <= seen_sps_next;
      seen_pps       <= seen_pps_next;
      cur_sps        <= cur_sps_next;
      cur_pps        <= cur_pps_next;
    end
  end

  // byte classification and next state
  always_comb begin
    phase_next          = phase;
    length_high_next    = length_high;
    bytes_left_next     = bytes_left;
    current_length_next = current_length;
    unit_count_next     = unit_count;
    current_type_next   = current_type;
    stored_nri_next     = stored_nri;
    seen_sps_next       = seen_sps;
    seen_pps_next       = seen_pps;
    cur_sps_next        = cur_sps;
    cur_pps_next        = cur_pps;

    res             = '0;
    res.kind        = sapd_pkg::KIND_DISCARD;
    res.out_byte    = beat.data_byte;
    res.packet_end  = beat.packet_last;
    res.error_code  = sapd_pkg::ERR_NONE;

    case (phase)
      sapd_pkg::PH_HEADER: begin
        res.kind = sapd_pkg::KIND_HEADER;
        if (beat.data_byte[7]) begin
          res.error_code = sapd_pkg::ERR_FORBIDDEN;
          phase_next     = sapd_pkg::PH_DISCARD;
        end else begin
          stored_nri_next = beat.data_byte[6:5];
          phase_next      = sapd_pkg::PH_LEN_HI;
        end
      end
      sapd_pkg::PH_LEN_HI: begin
        if (unit_count >= sapd_pkg::UCNT_W'(sapd_pkg::MAX_UNITS)) begin
          res.error_code = sapd_pkg::ERR_TOO_MANY;
          phase_next     = sapd_pkg::PH_DISCARD;
        end else begin
          res.kind         = sapd_pkg::KIND_LENGTH;
          res.unit_index   = count_wide[3:0];
          length_high_next = beat.data_byte;
          if (beat.packet_last) begin
            res.error_code = sapd_pkg::ERR_TRUNC_LENGTH;
          end
          phase_next = sapd_pkg::PH_LEN_LO;
        end
      end
      sapd_pkg::PH_LEN_LO: begin
        res.kind            = sapd_pkg::KIND_LENGTH;
        res.unit_index      = count_wide[3:0];
        res.unit_length     = new_length;
        current_length_next = new_length;
        bytes_left_next     = new_length;
        if (new_length == 16'd0) begin
          // empty unit: counted, no body
          unit_count_next = unit_count + 1'b1;
          phase_next      = sapd_pkg::PH_LEN_HI;
        end else begin
          if (beat.packet_last) begin
            res.error_code = sapd_pkg::ERR_TRUNC_BODY;
          end
          phase_next = sapd_pkg::PH_BODY;
        end
      end
      sapd_pkg::PH_BODY: begin
        res.kind        = sapd_pkg::KIND_PAYLOAD;
        res.unit_index  = count_wide[3:0];
        res.unit_length = current_length;
        res.unit_first  = body_first;
        res.unit_type   = body_type;
        res.first_sps   = body_sps;
        res.first_pps   = body_pps;
        // first body byte fixes the unit type and the first sps/pps marks
        if (body_first) begin
          current_type_next = beat.data_byte[4:0];
          cur_sps_next      = body_sps;
          cur_pps_next      = body_pps;
          seen_sps_next     = seen_sps || body_sps;
          seen_pps_next     = seen_pps || body_pps;
        end
        if (bytes_left <= 16'd1) begin
          res.unit_final  = 1'b1;
          bytes_left_next = '0;
          unit_count_next = unit_count + 1'b1;
          cur_sps_next    = 1'b0;
          cur_pps_next    = 1'b0;
          phase_next      = sapd_pkg::PH_LEN_HI;
        end else begin
          bytes_left_next = bytes_left - 16'd1;
          if (beat.packet_last) begin
            res.error_code = sapd_pkg::ERR_TRUNC_BODY;
          end
        end
      end
      default: begin
        res.kind = sapd_pkg::KIND_DISCARD;
      end
    endcase

    res.ref_idc = stored_nri_next;

    // end of packet returns everything to the header state
    if (beat.packet_last) begin
      phase_next          = sapd_pkg::PH_HEADER;
      length_high_next    = '0;
      bytes_left_next     = '0;
      current_length_next = '0;
      unit_count_next     = '0;
      current_type_next   = '0;
      stored_nri_next     = '0;
      seen_sps_next       = 1'b0;
      seen_pps_next       = 1'b0;
      cur_sps_next        = 1'b0;
      cur_pps_next        = 1'b0;
    end
  end

  // unit count stays within capacity
  assert property (@(posedge clk) disable iff (rst)
    unit_count <= sapd_pkg::UCNT_W'(sapd_pkg::MAX_UNITS))
    else $error("unit count above capacity");

  // a packet end always brings the parser back to the header
  assert property (@(posedge clk) disable iff (rst)
    take && beat.packet_last |=> phase == sapd_pkg::PH_HEADER)
    else $error("parser not at header after packet end");

  // no nri is held while waiting for a header
  assert property (@(posedge clk) disable iff (rst)
    phase == sapd_pkg::PH_HEADER |-> stored_nri == 2'd0 && unit_count == '0)
    else $error("stale packet state at header");

  // inside a body the remaining count is nonzero and within the unit length
  assert property (@(posedge clk) disable iff (rst)
    phase == sapd_pkg::PH_BODY |-> bytes_left != 16'd0 && bytes_left <= current_length)
    else $error("body byte count out of range");

endmodule

### src/sapd_out_stage.sv
module sapd_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  sapd_pkg::result_t res,
  output logic              free,
  sapd_result_if.source     result
);

  sapd_pkg::result_t held;

  // register can take a new result when empty or being read out
  assign free = !result.valid || result.ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (free) begin
      result.valid <= load;
    end
  end

  // result capture
  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign result.kind        = held.kind;
  assign result.out_byte    = held.out_byte;
  assign result.unit_index  = held.unit_index;
  assign result.unit_length = held.unit_length;
  assign result.unit_first  = held.unit_first;
  assign result.unit_final  = held.unit_final;
  assign result.unit_type   = held.unit_type;
  assign result.ref_idc     = held.ref_idc;
  assign result.first_sps   = held.first_sps;
  assign result.first_pps   = held.first_pps;
  assign result.packet_end  = held.packet_end;
  assign result.error_code  = held.error_code;

endmodule

### src/stap_a_deaggregator_core.sv
// STAP-A deaggregator: splits an H.264 aggregation packet into its NAL units.
// payload: one packet byte per beat, packet_last set on the final byte.
// result: one beat per input byte classifying it as header, length, unit
//   payload or discarded, with unit index, declared length, unit type, NRI,
//   first SPS / first PPS marks, packet end and an error code.
// Errors (forbidden bit, truncated length or body, too many units) are
//   reported on the byte where they are found; the rest of that packet is
//   then reported as discarded.
// Path: a byte accepted on payload passes through two register stages
//   (input register, then result register) before it appears on result.
// Throughput: one byte per clock while result is ready; the input register
//   drains into the result register in the same cycle the parser advances.
// Reset: rst clears both stage valid flags and the packet state, so the
//   next byte accepted is taken as a STAP header.
// Stall: when result is not ready, the result register holds, the input
//   register fills and payload.ready drops; no beat is lost or repeated.
module stap_a_deaggregator_core (
  input  logic          clk,
  input  logic          rst,
  sapd_byte_if.sink     payload,
  sapd_result_if.source result
);

  logic              beat_valid;
  logic              take;
  logic              free;
  sapd_pkg::beat_t   beat;
  sapd_pkg::result_t res;

  // move a byte through the parser when the result register has room
  assign take = beat_valid && free;

  sapd_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .payload    (payload),
    .take       (take),
    .beat_valid (beat_valid),
    .beat       (beat)
  );

  sapd_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .beat (beat),
    .res  (res)
  );

  sapd_out_stage u_out_stage (
    .clk    (clk),
    .rst    (rst),
    .load   (take),
    .res    (res),
    .free   (free),
    .result (result)
  );

endmodule
